### design/perd_pkg.sv
// Package for the per-ID event rate detector.
// Holds sizes, field widths, configuration indexes and shared types; no dependencies.
package perd_pkg;

  localparam int unsigned TRACKERS           = 128;
  localparam int unsigned EVENTS_PER_TRACKER = 64;

  localparam int unsigned SLOT_W  = $clog2(TRACKERS);
  localparam int unsigned POS_W   = $clog2(EVENTS_PER_TRACKER);
  localparam int unsigned CNT_W   = $clog2(EVENTS_PER_TRACKER + 1);
  localparam int unsigned USED_W  = $clog2(TRACKERS + 1);
  localparam int unsigned EVADDR_W = SLOT_W + POS_W;
  localparam int unsigned EVDEPTH = TRACKERS * EVENTS_PER_TRACKER;

  localparam int unsigned ID_W  = 22;
  localparam int unsigned TS_W  = 48;
  localparam int unsigned WIN_W = 32;
  localparam int unsigned THR_W = 7;
  localparam int unsigned CHK_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd2;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  // Per-tracker metadata, kept in one memory word.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] wpos;
    logic [TS_W-1:0]  last_check;
    logic [CNT_W-1:0] recent;
    logic             reported;
    logic [TS_W-1:0]  newest;
  } slot_meta_t;

  localparam int unsigned META_W = $bits(slot_meta_t);

  typedef struct packed {
    logic             alert;
    logic [CNT_W-1:0] recent;
    logic             hit;
    logic             evicted;
  } result_t;

endpackage

### design/perd_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module perd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### design/per_id_event_rate_detector.sv
// Per-ID event rate detector: sequencer over tracker and event memories. Uses perd_pkg, perd_ram.
// Flow: an ID-zero item goes from S_SRCH straight to S_OUT; a search that misses
// a full table then scans it for the oldest tracker in S_OLD and S_OCMP, and a hit
// on the last slot with a full ring walk passes through S_WALK and S_WCMP before S_WB.
// Throughput: one item at a time; in_stall_o is high from acceptance until the result transfer.
// Reset: asynchronous, active low; a clearing pass over the tracker memory follows, with no transfer in.
module per_id_event_rate_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [perd_pkg::ID_W-1:0]    source_id_i,
  input  logic [perd_pkg::TS_W-1:0]    timestamp_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         alert_o,
  output logic [perd_pkg::CNT_W-1:0]   win_count_o,
  output logic                         hit_o,
  output logic                         evicted_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [perd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import perd_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SRCH   = 4'd2;  // address slot, wait for read
  localparam logic [3:0] S_SCMP   = 4'd3;  // compare read slot
  localparam logic [3:0] S_OLD    = 4'd4;  // oldest search issue
  localparam logic [3:0] S_OCMP   = 4'd5;
  localparam logic [3:0] S_UPD    = 4'd8;  // append timestamp, decide check
  localparam logic [3:0] S_WALK   = 4'd9;
  localparam logic [3:0] S_WCMP   = 4'd10;
  localparam logic [3:0] S_WB     = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_q, state_d;

  // Configuration registers; writes are always taken.
  logic [WIN_W-1:0] window_q;
  logic [THR_W-1:0] thresh_q;
  logic [CHK_W-1:0] interval_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WIN_W'(10000);
      thresh_q   <= THR_W'(5);
      interval_q <= CHK_W'(500);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WINDOW:    window_q   <= cfg_data_i;
        CFG_THRESHOLD: thresh_q   <= cfg_data_i[THR_W-1:0];
        CFG_INTERVAL:  interval_q <= cfg_data_i[CHK_W-1:0];
        default: ;
      endcase
    end
  end

  // Item registers.
  logic             cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [TS_W-1:0]  now_q;
  logic [USED_W-1:0] used_q, used_d;
  logic [SLOT_W:0]  idx_q, idx_d;      // scan index, one bit wider to hold the end
  logic [SLOT_W-1:0] sel_q, sel_d;     // chosen slot
  logic [TS_W-1:0]  oldest_q, oldest_d;
  logic [CNT_W-1:0] n_q, n_d;          // walk step / in-window count
  slot_meta_t       cur_q, cur_d;
  result_t          res_q, res_d;

  // Metadata memory.
  logic              meta_we;
  logic [SLOT_W-1:0] meta_addr;
  slot_meta_t        meta_wdata, meta_rdata;
  logic [META_W-1:0] meta_rraw;

  perd_ram #(.WIDTH(META_W), .DEPTH(TRACKERS)) u_meta (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .addr_i (meta_addr),
    .wdata_i(meta_wdata),
    .rdata_o(meta_rraw)
  );
  assign meta_rdata = slot_meta_t'(meta_rraw);

  // Event timestamp memory, one ring of EVENTS_PER_TRACKER entries per slot.
  logic                ev_we;
  logic [EVADDR_W-1:0] ev_addr;
  logic [TS_W-1:0]     ev_rdata;

  perd_ram #(.WIDTH(TS_W), .DEPTH(EVDEPTH)) u_events (
    .clk_i  (clk_i),
    .we_i   (ev_we),
    .addr_i (ev_addr),
    .wdata_i(now_q),
    .rdata_o(ev_rdata)
  );

  logic accept;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign alert_o     = res_q.alert;
  assign win_count_o = res_q.recent;
  assign hit_o       = res_q.hit;
  assign evicted_o   = res_q.evicted;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      id_q  <= source_id_i;
      now_q <= timestamp_ms_i;
    end
  end

  // Combinational helpers.
  logic [TS_W-1:0]  elapsed, age;
  logic [POS_W-1:0] walk_pos;
  logic [TS_W-1:0]  meta_newest;
  assign elapsed  = now_q - cur_q.last_check;
  assign age      = now_q - ev_rdata;
  // Position of the entry n_q steps back from the newest.
  assign walk_pos = cur_q.wpos - POS_W'(n_q) - POS_W'(1);
  assign meta_newest = (meta_rdata.count != '0) ? meta_rdata.newest : '0;

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    idx_d      = idx_q;
    sel_d      = sel_q;
    oldest_d   = oldest_q;
    n_d        = n_q;
    cur_d      = cur_q;
    res_d      = res_q;
    meta_we    = 1'b0;
    meta_addr  = idx_q[SLOT_W-1:0];
    meta_wdata = cur_q;
    ev_we      = 1'b0;
    ev_addr    = {sel_q, walk_pos};

    case (state_q)
      S_CLEAR: begin
        // Clearing pass over the metadata memory after reset.
        meta_we    = 1'b1;
        meta_wdata = '0;
        idx_d      = idx_q + 1'b1;
        if (idx_q == (SLOT_W+1)'(TRACKERS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        res_d = '0;
        idx_d = '0;
        if (accept) begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (id_q == '0) begin
          state_d = S_OUT;
        end else if (idx_q >= (SLOT_W+1)'(used_q)) begin
          // Not present.
          if (cmd_q == CMD_RESET) begin
            state_d = S_OUT;
          end else if (used_q < USED_W'(TRACKERS)) begin
            sel_d   = used_q[SLOT_W-1:0];
            used_d  = used_q + 1'b1;
            cur_d   = '0;
            cur_d.id = id_q;
            cur_d.last_check = now_q;
            state_d = S_UPD;
          end else begin
            idx_d   = '0;
            state_d = S_OLD;
          end
        end else begin
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (meta_rdata.id == id_q) begin
          sel_d     = idx_q[SLOT_W-1:0];
          res_d.hit = 1'b1;
          if (cmd_q == CMD_RESET) begin
            cur_d            = '0;
            cur_d.id         = id_q;
            cur_d.last_check = now_q;
            state_d          = S_WB;
          end else begin
            cur_d   = meta_rdata;
            state_d = S_UPD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRCH;
        end
      end
      S_OLD: begin
        if (idx_q == (SLOT_W+1)'(TRACKERS)) begin
          cur_d            = '0;
          cur_d.id         = id_q;
          cur_d.last_check = now_q;
          res_d.evicted    = 1'b1;
          state_d          = S_UPD;
        end else begin
          state_d = S_OCMP;
        end
      end
      S_OCMP: begin
        if (idx_q == '0 || meta_newest < oldest_q) begin
          oldest_d = meta_newest;
          sel_d    = idx_q[SLOT_W-1:0];
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_OLD;
      end
      S_UPD: begin
        // Append the timestamp to the ring.
        ev_we       = 1'b1;
        ev_addr     = {sel_q, cur_q.wpos};
        cur_d.wpos  = cur_q.wpos + 1'b1;
        cur_d.newest = now_q;
        if (cur_q.count < CNT_W'(EVENTS_PER_TRACKER)) begin
          cur_d.count = cur_q.count + 1'b1;
        end
        n_d = '0;
        if (elapsed < TS_W'(interval_q)) begin
          res_d.recent = cur_q.recent;
          state_d      = S_WB;
        end else begin
          cur_d.last_check = now_q;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (n_q >= cur_q.count) begin
          cur_d.recent    = n_q;
          res_d.recent    = n_q;
          cur_d.reported  = (n_q >= thresh_q);
          res_d.alert     = (n_q >= thresh_q) && !cur_q.reported;
          state_d         = S_WB;
        end else begin
          state_d = S_WCMP;
        end
      end
      S_WCMP: begin
        if (age <= TS_W'(window_q)) begin
          n_d     = n_q + 1'b1;
          state_d = S_WALK;
        end else begin
          cur_d.recent   = n_q;
          res_d.recent   = n_q;
          cur_d.reported = (n_q >= thresh_q);
          res_d.alert    = (n_q >= thresh_q) && !cur_q.reported;
          state_d        = S_WB;
        end
      end
      S_WB: begin
        meta_we   = 1'b1;
        meta_addr = sel_q;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    oldest_q <= oldest_d;
    n_q      <= n_d;
    cur_q    <= cur_d;
    res_q    <= res_d;
  end
endmodule

### bench/tb_per_id_event_rate_detector.sv
// Self-checking testbench for the per-ID event rate detector.
// Depends on perd_pkg and the per_id_event_rate_detector RTL; holds its own tracker predictor.
module tb_per_id_event_rate_detector;
  import perd_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE     = 4 * TRACKERS + 2 * EVENTS_PER_TRACKER;
  localparam int unsigned PHASES     = 6;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_RECORD;
  logic [ID_W-1:0]      source_id = '0;
  logic [TS_W-1:0]      timestamp_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 alert;
  logic [CNT_W-1:0]     win_count;
  logic                 hit;
  logic                 evicted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
  logic [31:0]          cfg_data = '0;

  per_id_event_rate_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .source_id_i    (source_id),
    .timestamp_ms_i (timestamp_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .alert_o        (alert),
    .win_count_o    (win_count),
    .hit_o          (hit),
    .evicted_o      (evicted),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the tracker table and the registers, as the block should hold them.
  logic [ID_W-1:0]  trk_owner [TRACKERS];
  int unsigned      trk_used;
  logic [CNT_W-1:0] trk_count [TRACKERS];
  logic [POS_W-1:0] trk_wpos [TRACKERS];
  logic [TS_W-1:0]  trk_checked [TRACKERS];
  logic [CNT_W-1:0] trk_recent [TRACKERS];
  logic             trk_flagged [TRACKERS];
  logic [TS_W-1:0]  ring_ts [TRACKERS][EVENTS_PER_TRACKER];
  logic [WIN_W-1:0] cur_window = 32'd10000;
  logic [THR_W-1:0] cur_threshold = 7'd5;
  logic [CHK_W-1:0] cur_interval = 16'd500;

  result_t     expected_results[$];
  int unsigned errors = 0;
  int unsigned burst_left = 0;

  // A tracker cleared for a new owner, or for its own owner on a reset command.
  function automatic void clear_tracker(int unsigned s, logic [ID_W-1:0] id, logic [TS_W-1:0] now);
    trk_owner[s]   = id;
    trk_count[s]   = '0;
    trk_wpos[s]    = '0;
    trk_checked[s] = now;
    trk_recent[s]  = '0;
    trk_flagged[s] = 1'b0;
  endfunction

  // Works out the result of one transfer and moves the shadow table on by it.
  function automatic result_t rate_predict(logic c, logic [ID_W-1:0] id, logic [TS_W-1:0] now);
    result_t          r;
    int               found;
    int unsigned      s;
    logic [TS_W-1:0]  oldest;
    logic [TS_W-1:0]  newest;
    logic [POS_W-1:0] p;
    logic [CNT_W-1:0] n;
    logic             susp;
    r = '0;
    found = -1;
    s = 0;
    if (id == '0) return r;
    for (int unsigned i = 0; i < trk_used; i++) begin
      if (found < 0 && trk_owner[i] == id) found = i;
    end
    if (c == CMD_RESET) begin
      if (found >= 0) begin
        clear_tracker(found, id, now);
        r.hit = 1'b1;
      end
      return r;
    end
    if (found >= 0) begin
      s = found;
      r.hit = 1'b1;
    end else if (trk_used < TRACKERS) begin
      s = trk_used;
      trk_used++;
      clear_tracker(s, id, now);
    end else begin
      // Evict the tracker whose newest event is oldest; the lowest index wins a tie.
      oldest = '1;
      for (int unsigned i = 0; i < TRACKERS; i++) begin
        newest = (trk_count[i] != 0) ? ring_ts[i][trk_wpos[i] - 1'b1] : '0;
        if (i == 0 || newest < oldest) begin
          oldest = newest;
          s = i;
        end
      end
      clear_tracker(s, id, now);
      r.evicted = 1'b1;
    end
    ring_ts[s][trk_wpos[s]] = now;
    trk_wpos[s] = trk_wpos[s] + 1'b1;
    if (trk_count[s] < EVENTS_PER_TRACKER) trk_count[s] = trk_count[s] + 1'b1;
    if (TS_W'(now - trk_checked[s]) < {32'b0, cur_interval}) begin
      r.recent = trk_recent[s];
    end else begin
      trk_checked[s] = now;
      n = '0;
      for (int unsigned i = 0; i < trk_count[s]; i++) begin
        p = trk_wpos[s] - POS_W'(i + 1);
        if (TS_W'(now - ring_ts[s][p]) > {16'b0, cur_window}) break;
        n = n + 1'b1;
      end
      trk_recent[s] = n;
      r.recent = n;
      susp = (n >= cur_threshold);
      r.alert = susp && !trk_flagged[s];
      trk_flagged[s] = susp;
    end
    return r;
  endfunction

  task automatic report(string fld, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d", fld, got, want);
  endtask

  // Offers one item and holds it until the transfer takes place. Between bursts the
  // sender drops valid for a random pause; within a burst valid simply stays high.
  task automatic send_item(logic c, logic [ID_W-1:0] id, logic [TS_W-1:0] ts,
                           bit typed, result_t want);
    result_t pred;
    in_valid     <= 1'b1;
    cmd          <= c;
    source_id    <= id;
    timestamp_ms <= ts;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    pred = rate_predict(c, id, ts);
    expected_results.push_back(typed ? want : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Register writes happen only once every outstanding result has come back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_WINDOW:    cur_window = value;
      CFG_THRESHOLD: cur_threshold = value[THR_W-1:0];
      CFG_INTERVAL:  cur_interval = value[CHK_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // The receiver stalls at random, except in one stretch out of every four where it never does.
  int unsigned cycle_no = 0;
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no[10:9] == 2'd0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Result checker: each transfer out is matched against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (alert !== want.alert) report("alert", alert, want.alert);
        if (win_count !== want.recent) report("win_count", win_count, want.recent);
        if (hit !== want.hit) report("hit", hit, want.hit);
        if (evicted !== want.evicted) report("evicted", evicted, want.evicted);
      end
    end
  end

  // Watchdog: a long run of cycles without any transfer on any channel means a hang.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  typedef struct packed {
    logic            c;
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] ts;
    logic            typed;
    result_t         want;
  } stim_row_t;

  // Directed rows at the reset settings (window 10000, threshold 5, interval 500).
  // A result is typed in only where it is plain; the rest go to the predictor.
  localparam result_t NONE = '0;
  localparam result_t HIT  = '{alert: 1'b0, recent: '0, hit: 1'b1, evicted: 1'b0};
  stim_row_t directed [17] = '{
    '{CMD_RECORD, 22'd0,        48'd0,            1'b1, NONE}, // ID zero is ignored
    '{CMD_RESET,  22'd5,        48'd0,            1'b1, NONE}, // reset of an absent ID
    '{CMD_RECORD, 22'd5,        48'd1000,         1'b1, NONE}, // new tracker, no check due
    '{CMD_RECORD, 22'd5,        48'd1100,         1'b1, HIT},
    '{CMD_RECORD, 22'd5,        48'd1200,         1'b0, NONE},
    '{CMD_RECORD, 22'd5,        48'd1300,         1'b0, NONE},
    '{CMD_RECORD, 22'd5,        48'd1600,         1'b0, NONE}, // reaches the threshold
    '{CMD_RECORD, 22'd5,        48'd2200,         1'b0, NONE}, // stays suspicious, no alert
    '{CMD_RESET,  22'd5,        48'd2300,         1'b1, HIT},  // reset of a present ID
    '{CMD_RECORD, 22'd5,        48'd2400,         1'b0, NONE},
    '{CMD_RECORD, 22'h3FFFFF,   48'd2500,         1'b1, NONE},
    '{CMD_RECORD, 22'h3FFFFF,   48'hFFFFFFFFFFFF, 1'b0, NONE}, // largest time
    '{CMD_RECORD, 22'h3FFFFF,   48'd3000,         1'b0, NONE}, // time going backwards
    '{CMD_RESET,  22'd0,        48'd3000,         1'b1, NONE},
    '{CMD_RECORD, 22'h2AAAAA,   48'd3000,         1'b1, NONE},
    '{CMD_RECORD, 22'h155555,   48'd5000,         1'b1, NONE},
    '{CMD_RECORD, 22'h155555,   48'd20000,        1'b0, NONE}
  };

  // Each random phase has its own settings, ID pool and pace of time.
  // The wide pools push the table past full so that evictions take place.
  logic [31:0] ph_window [PHASES] = '{32'd1, 32'hFFFFFFFF, 32'd2000, 32'd500, 32'd10000, 32'd300};
  logic [31:0] ph_thresh [PHASES] = '{32'd1, 32'd64, 32'd0, 32'd3, 32'd5, 32'd2};
  logic [31:0] ph_interv [PHASES] = '{32'd0, 32'd65535, 32'd0, 32'd100, 32'd500, 32'd1};
  int unsigned ph_pool   [PHASES] = '{4, 300, 8, 300, 16, 6};
  int unsigned ph_items  [PHASES] = '{70, 70, 70, 90, 80, 70};
  int unsigned ph_step   [PHASES] = '{2, 3000, 300, 60, 400, 1};

  initial begin
    logic [ID_W-1:0] pool[$];
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] now;
    logic            c;
    int unsigned     pick;
    trk_used = 0;
    foreach (trk_owner[i]) clear_tracker(i, '0, '0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_item(directed[i].c, directed[i].id, directed[i].ts, directed[i].typed, directed[i].want);
    end
    in_valid <= 1'b0;
    burst_left = 0;
    now = 48'd30000;

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_WINDOW, ph_window[ph]);
      write_reg(CFG_THRESHOLD, ph_thresh[ph]);
      write_reg(CFG_INTERVAL, ph_interv[ph]);
      pool.delete();
      repeat (ph_pool[ph]) pool.push_back(ID_W'($urandom_range(1, 22'h3FFFFF)));
      for (int unsigned k = 0; k < ph_items[ph]; k++) begin
        pick = $urandom_range(0, 99);
        id = pool[$urandom_range(0, pool.size() - 1)];
        c = CMD_RECORD;
        if (pick < 3) begin
          id = '0;
        end else if (pick < 5) begin
          id = '0;
          c = CMD_RESET;
        end else if (pick < 11) begin
          c = CMD_RESET;
        end
        // Now and then time jumps anywhere, backwards included; otherwise it creeps on.
        if ($urandom_range(0, 99) < 2) begin
          now = TS_W'({$urandom, $urandom});
        end else begin
          now = now + TS_W'($urandom_range(0, ph_step[ph]));
        end
        send_item(c, id, now, 1'b0, NONE);
      end
      in_valid <= 1'b0;
      burst_left = 0;
    end

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
